>>> hw/rtl/cvgf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvgf_pkg: shared types and codes for the clipped vertical gradient fill
// Item layouts for both channels, result status codes, register indexes and
// the default surface dimension limit.
// ----------------------------------------------------------------------------
package cvgf_pkg;

    // Default limit on surface width and height, in pixels.
    localparam int CVGF_MAX_DIM = 4096;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_ROW     = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;
    localparam logic [1:0] STAT_IDLE    = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID  = 3'd4;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic [31:0]        top_color;
        logic [31:0]        bottom_color;
    } cvgf_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] row_address;
        logic [12:0] span_words;
        logic [31:0] pixel_value;
        logic        last_row;
    } cvgf_out_t;

endpackage : cvgf_pkg
`default_nettype wire

>>> hw/rtl/clipped_vertical_gradient_fill.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_vertical_gradient_fill: row span generator with vertical gradient
// Clips a fill rectangle to the surface and hands out one row span or status
// per item, with the row colour interpolated over the clipped height.
// ----------------------------------------------------------------------------
// A start item (operation 0) clips its rectangle against the surface and
// returns the first row span; each next item (operation 1) returns the
// following row, with last_row marking the final one. Every item yields
// exactly one result item. The block takes one item at a time and takes no
// new item until the result of the last one has moved to the output
// register. A next item runs the shared restoring divider, which resolves
// one quotient bit per cycle over a 21-bit dividend, once for each of the R,
// G and B channels, with a setup state before and a finish state after each
// division; a start item that draws first clips its rectangle and works out
// the first row address. A start item that is rejected (invalid surface or
// empty rectangle) and a next item with no fill active go straight to the
// output. A result sits in an output register until it is taken, and the
// block already accepts the next item while it waits. Configuration
// registers are written through the plain write port and should only be
// changed while the block is idle.
module clipped_vertical_gradient_fill
    import cvgf_pkg::*;
#(
    parameter int MAX_DIM = CVGF_MAX_DIM
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [31:0]          cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire cvgf_in_t             s_item,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output cvgf_out_t                 m_item
);

    // Register fields are 13 bits wide, so the effective limit never exceeds
    // what such a field can hold.
    localparam logic [12:0] DIM_CLAMP = 13'((MAX_DIM > 8191) ? 8191 : MAX_DIM);

    // Dividend width: an 8-bit colour difference times a 13-bit row index.
    localparam int DVD_W     = 21;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;  // waiting for an item
    localparam logic [3:0] ST_EVAL = 4'd1;  // decode and clip
    localparam logic [3:0] ST_ADDR = 4'd2;  // first row offset product
    localparam logic [3:0] ST_BASE = 4'd3;  // first row address sum
    localparam logic [3:0] ST_MUL  = 4'd4;  // channel numerator setup
    localparam logic [3:0] ST_DIV  = 4'd5;  // one quotient bit per cycle
    localparam logic [3:0] ST_FIN  = 4'd6;  // sign fix and channel store
    localparam logic [3:0] ST_EMIT = 4'd7;  // assemble the row span
    localparam logic [3:0] ST_OUT  = 4'd8;  // hand result to the output

    // Configuration registers.
    logic [31:0] base_reg;
    logic [12:0] sw_reg;
    logic [12:0] sh_reg;
    logic [15:0] stride_reg;
    logic        svalid_reg;

    // Fill state.
    logic        fill_active_reg;
    logic [12:0] row_reg;
    logic [12:0] height_reg;
    logic [12:0] width_reg;
    logic [31:0] addr_reg;
    logic [23:0] start_rgb_reg;
    logic [23:0] end_rgb_reg;

    // Sequencer and datapath registers.
    logic [3:0]       state_reg;
    cvgf_in_t         in_reg;
    logic [12:0]      x_reg;
    logic [12:0]      y_reg;
    logic [28:0]      prod_reg;
    logic [1:0]       chan_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [12:0]      rem_reg;
    logic [12:0]      den_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [23:0]      px_reg;
    cvgf_out_t        res_reg;

    logic             m_valid_reg;
    cvgf_out_t        m_item_reg;

    // ------------------------------------------------------------------
    // Clipping. Negative origins shrink the size; spans that run past the
    // surface are cut back to its edge.
    // ------------------------------------------------------------------
    logic signed [17:0] cx, cy, cw, ch, sw18, sh18;
    logic [12:0]        sw_lim, sh_lim;
    logic               clip_empty;

    always_comb begin
        sw_lim = (sw_reg > DIM_CLAMP) ? DIM_CLAMP : sw_reg;
        sh_lim = (sh_reg > DIM_CLAMP) ? DIM_CLAMP : sh_reg;
        sw18   = signed'({5'b0, sw_lim});
        sh18   = signed'({5'b0, sh_lim});
        cx     = {{2{in_reg.rect_x[15]}}, in_reg.rect_x};
        cy     = {{2{in_reg.rect_y[15]}}, in_reg.rect_y};
        cw     = {{2{in_reg.rect_w[15]}}, in_reg.rect_w};
        ch     = {{2{in_reg.rect_h[15]}}, in_reg.rect_h};
        if (cx < 0) begin
            cw = cw + cx;
            cx = '0;
        end
        if (cy < 0) begin
            ch = ch + cy;
            cy = '0;
        end
        if (cx + cw > sw18) begin
            cw = sw18 - cx;
        end
        if (cy + ch > sh18) begin
            ch = sh18 - cy;
        end
        clip_empty = (in_reg.rect_w <= 0) || (in_reg.rect_h <= 0) ||
                     (cw <= 0) || (ch <= 0);
    end

    // ------------------------------------------------------------------
    // Channel selection and the shared divider step.
    // ------------------------------------------------------------------
    logic [7:0]         c0, c1;
    logic signed [8:0]  diff;
    logic [7:0]         diff_mag;
    logic [12:0]        row_num;
    logic [13:0]        trial;
    logic               qbit;
    logic signed [22:0] qs;
    logic signed [22:0] csum;
    logic [7:0]         cval;
    logic               last_row;

    always_comb begin
        unique case (chan_reg)
            2'd0: begin
                c0 = start_rgb_reg[23:16];
                c1 = end_rgb_reg[23:16];
            end
            2'd1: begin
                c0 = start_rgb_reg[15:8];
                c1 = end_rgb_reg[15:8];
            end
            default: begin
                c0 = start_rgb_reg[7:0];
                c1 = end_rgb_reg[7:0];
            end
        endcase
        diff     = signed'({1'b0, c1}) - signed'({1'b0, c0});
        diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
        row_num  = (height_reg > 13'd1) ? row_reg : 13'd0;

        trial = {rem_reg, dvd_reg[DVD_W-1]};
        qbit  = (trial >= {1'b0, den_reg});

        qs   = neg_reg ? -signed'({2'b0, dvd_reg}) : signed'({2'b0, dvd_reg});
        csum = signed'({15'b0, c0}) + qs;
        if (csum < 0) begin
            cval = 8'd0;
        end else if (csum > 23'sd255) begin
            cval = 8'hFF;
        end else begin
            cval = csum[7:0];
        end

        last_row = ({1'b0, row_reg} + 14'd1 >= {1'b0, height_reg});
    end

    // ------------------------------------------------------------------
    // Sequencer, registers and output stage.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg        <= '0;
            sw_reg          <= '0;
            sh_reg          <= '0;
            stride_reg      <= '0;
            svalid_reg      <= 1'b0;
            fill_active_reg <= 1'b0;
            row_reg         <= '0;
            height_reg      <= '0;
            width_reg       <= '0;
            addr_reg        <= '0;
            start_rgb_reg   <= '0;
            end_rgb_reg     <= '0;
            state_reg       <= ST_IDLE;
            chan_reg        <= '0;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BASE:   base_reg   <= cfg_wdata;
                    CFG_WIDTH:  sw_reg     <= cfg_wdata[12:0];
                    CFG_HEIGHT: sh_reg     <= cfg_wdata[12:0];
                    CFG_STRIDE: stride_reg <= cfg_wdata[15:0];
                    CFG_VALID:  svalid_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            // A new result fills the output register once it is free or
            // being taken; otherwise a taken result empties it.
            if ((state_reg == ST_OUT) && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_item;
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    chan_reg <= '0;
                    if (in_reg.operation == OP_NEXT) begin
                        if (!fill_active_reg) begin
                            res_reg   <= '{status: STAT_IDLE, default: '0};
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end else begin
                        fill_active_reg <= 1'b0;
                        if (!svalid_reg) begin
                            res_reg   <= '{status: STAT_INVALID, default: '0};
                            state_reg <= ST_OUT;
                        end else if (clip_empty) begin
                            res_reg   <= '{status: STAT_EMPTY, default: '0};
                            state_reg <= ST_OUT;
                        end else begin
                            x_reg         <= cx[12:0];
                            y_reg         <= cy[12:0];
                            width_reg     <= cw[12:0];
                            height_reg    <= ch[12:0];
                            row_reg       <= '0;
                            start_rgb_reg <= in_reg.top_color[23:0];
                            end_rgb_reg   <= in_reg.bottom_color[23:0];
                            state_reg     <= ST_ADDR;
                        end
                    end
                end
                ST_ADDR: begin
                    prod_reg  <= y_reg * stride_reg;
                    state_reg <= ST_BASE;
                end
                ST_BASE: begin
                    addr_reg        <= base_reg + {3'b0, prod_reg} + {17'b0, x_reg, 2'b00};
                    fill_active_reg <= 1'b1;
                    state_reg       <= ST_MUL;
                end
                ST_MUL: begin
                    dvd_reg   <= diff_mag * row_num;
                    neg_reg   <= diff[8];
                    rem_reg   <= '0;
                    den_reg   <= (height_reg > 13'd1) ? height_reg - 13'd1 : 13'd1;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= qbit ? 13'(trial - {1'b0, den_reg}) : trial[12:0];
                    dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    unique case (chan_reg)
                        2'd0:    px_reg[23:16] <= cval;
                        2'd1:    px_reg[15:8]  <= cval;
                        default: px_reg[7:0]   <= cval;
                    endcase
                    if (chan_reg == 2'd2) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        chan_reg  <= chan_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_EMIT: begin
                    res_reg.status      <= STAT_ROW;
                    res_reg.row_address <= addr_reg;
                    res_reg.span_words  <= width_reg;
                    res_reg.pixel_value <= {8'hFF, px_reg};
                    res_reg.last_row    <= last_row;
                    if (last_row) begin
                        fill_active_reg <= 1'b0;
                    end else begin
                        row_reg  <= row_reg + 13'd1;
                        addr_reg <= addr_reg + {16'b0, stride_reg};
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // The result moves out once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg <= res_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An active fill always has a row left to emit.
    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> (row_reg < height_reg))
        else $error("active fill row index beyond clipped height");

    // The block takes one item at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again while busy");

    // Results other than a row span carry zero fields.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.status != STAT_ROW)) |->
            ((m_item.row_address == '0) && (m_item.span_words == '0) &&
             (m_item.pixel_value == '0) && (m_item.last_row == 1'b0)))
        else $error("non-row result with nonzero fields");

    // The divider never runs past its last step.
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_W'(DIV_STEPS - 1)))
        else $error("divider step count overran");

endmodule : clipped_vertical_gradient_fill
`default_nettype wire

>>> dv/clipped_vertical_gradient_fill_test.sv
// ----------------------------------------------------------------------------
// clipped_vertical_gradient_fill_test: self-checking bench for the gradient fill
// Drives start and next items through the valid/ready input channel, predicts
// every row span with an independent model of the clipping and colour ramp,
// and compares each result item field by field. A directed table comes first,
// then randomized phases with fresh surface settings, idle gaps on both sides,
// a stretch without gaps and one long receiver hold-off.
// ----------------------------------------------------------------------------
module clipped_vertical_gradient_fill_test;
    import cvgf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Sender and receiver idle in this many cycles out of a hundred.
    localparam int IDLE_PCT     = 23;
    localparam int RANDOM_ITEMS = 850;
    // Long receiver hold-off, far beyond the time the block needs to fill up.
    localparam int HOLD_CYCLES  = 600;
    // Covers the time a drawing item takes twice over.
    localparam int DRAIN_CYCLES = 160;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    cvgf_in_t             s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    cvgf_out_t            m_item;

    clipped_vertical_gradient_fill dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // The run is cut off at a time many times the length of a correct run.
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: the surface registers as the block holds them, and
    // the fill in progress.
    // ------------------------------------------------------------------
    logic [31:0] base_r   = '0;
    logic [12:0] width_r  = '0;
    logic [12:0] height_r = '0;
    logic [15:0] stride_r = '0;
    logic        valid_r  = 1'b0;

    logic        fill_on  = 1'b0;
    logic [12:0] row_idx  = '0;
    logic [12:0] fill_h   = '0;
    logic [12:0] fill_w   = '0;
    logic [31:0] row_addr = '0;
    logic [23:0] rgb_top  = '0;
    logic [23:0] rgb_bot  = '0;

    cvgf_out_t pending_spans[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        idle_pct   = IDLE_PCT;
    bit        hold_req   = 1'b0;

    // One colour channel of the current row. The ramp runs from the top
    // colour at row 0 to the bottom colour at the last clipped row, and the
    // division truncates toward zero, so a falling channel rounds upward.
    function automatic logic [7:0] ramp_channel(int shift);
        int c0, c1, num, den, c;
        c0  = int'(rgb_top[shift +: 8]);
        c1  = int'(rgb_bot[shift +: 8]);
        num = (fill_h > 13'd1) ? int'(row_idx) : 0;
        den = (fill_h > 13'd1) ? int'(fill_h) - 1 : 1;
        c   = c0 + (c1 - c0) * num / den;
        if (c < 0) c = 0;
        if (c > 255) c = 255;
        return c[7:0];
    endfunction

    // Emits the current row of the fill and advances to the next one. The
    // stride is the one in the register now, so a stride written during a
    // fill applies to the rows that follow.
    function automatic cvgf_out_t emit_span();
        cvgf_out_t r;
        logic      done;
        r             = '0;
        done          = (int'(row_idx) + 1 >= int'(fill_h));
        r.status      = STAT_ROW;
        r.row_address = row_addr;
        r.span_words  = fill_w;
        r.pixel_value = {8'hFF, ramp_channel(16), ramp_channel(8), ramp_channel(0)};
        r.last_row    = done;
        if (done) begin
            fill_on = 1'b0;
        end else begin
            row_idx  = row_idx + 13'd1;
            row_addr = row_addr + stride_r;
        end
        return r;
    endfunction

    // Works out the result of one accepted item and updates the fill state.
    function automatic cvgf_out_t predict_span(cvgf_in_t it);
        cvgf_out_t r;
        int        x, y, w, h, sw, sh;
        r = '0;
        if (it.operation == OP_NEXT) begin
            if (!fill_on) begin
                r.status = STAT_IDLE;
                return r;
            end
            return emit_span();
        end
        // Any start item ends the fill in progress, whatever it turns into.
        fill_on = 1'b0;
        if (!valid_r) begin
            r.status = STAT_INVALID;
            return r;
        end
        x = $signed(it.rect_x);
        y = $signed(it.rect_y);
        w = $signed(it.rect_w);
        h = $signed(it.rect_h);
        if (w <= 0 || h <= 0) begin
            r.status = STAT_EMPTY;
            return r;
        end
        sw = (int'(width_r) > CVGF_MAX_DIM) ? CVGF_MAX_DIM : int'(width_r);
        sh = (int'(height_r) > CVGF_MAX_DIM) ? CVGF_MAX_DIM : int'(height_r);
        // A negative origin eats into the size before the far edge is clipped.
        if (x < 0) begin
            w = w + x;
            x = 0;
        end
        if (y < 0) begin
            h = h + y;
            y = 0;
        end
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        if (w <= 0 || h <= 0) begin
            r.status = STAT_EMPTY;
            return r;
        end
        fill_w   = w[12:0];
        fill_h   = h[12:0];
        row_idx  = '0;
        rgb_top  = it.top_color[23:0];
        rgb_bot  = it.bottom_color[23:0];
        row_addr = base_r + 32'(y * int'(stride_r)) + 32'(x * 4);
        fill_on  = 1'b1;
        return emit_span();
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_val;
        cvgf_in_t             item;
        bit                   typed;
        cvgf_out_t            want;
    } plan_row_t;

    plan_row_t directed_plan[$];

    function automatic cvgf_in_t mk_item(logic op, int x, int y, int w, int h,
                                         logic [31:0] top, logic [31:0] bot);
        cvgf_in_t it;
        it.operation    = op;
        it.rect_x       = 16'(x);
        it.rect_y       = 16'(y);
        it.rect_w       = 16'(w);
        it.rect_h       = 16'(h);
        it.top_color    = top;
        it.bottom_color = bot;
        return it;
    endfunction

    function automatic cvgf_out_t mk_result(logic [1:0] st, logic [31:0] addr,
                                            logic [12:0] words, logic [31:0] px,
                                            logic last);
        cvgf_out_t r;
        r.status      = st;
        r.row_address = addr;
        r.span_words  = words;
        r.pixel_value = px;
        r.last_row    = last;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        plan_row_t p;
        p         = '{default: '0};
        p.is_reg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    function automatic plan_row_t item_row(cvgf_in_t it);
        plan_row_t p;
        p      = '{default: '0};
        p.item = it;
        return p;
    endfunction

    function automatic plan_row_t typed_row(cvgf_in_t it, cvgf_out_t want);
        plan_row_t p;
        p       = item_row(it);
        p.typed = 1'b1;
        p.want  = want;
        return p;
    endfunction

    function automatic logic [12:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'd4096;
            2:       return 13'($urandom_range(4097, 8191));
            3:       return 13'd1;
            default: return 13'($urandom_range(2, 300));
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A next item carries a rectangle too; the block must not look at it.
    function automatic cvgf_in_t next_item();
        return mk_item(OP_NEXT, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
    endfunction

    // Offers one item, possibly after an idle gap, and records what it must
    // produce once it is accepted. A row with a typed result uses that value
    // as the expectation but still runs the predictor to keep its state.
    task automatic offer(cvgf_in_t it, bit typed = 1'b0, cvgf_out_t want = '0);
        cvgf_out_t predicted;
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_span(it);
        pending_spans.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Registers may only change once every result has been taken.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Write enable is left high so back-to-back writes never lower and raise
    // it in one step; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_BASE:   base_r   = val;
            CFG_WIDTH:  width_r  = val[12:0];
            CFG_HEIGHT: height_r = val[12:0];
            CFG_STRIDE: stride_r = val[15:0];
            CFG_VALID:  valid_r  = val[0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, and on request one long hold-off
    // counted here while the sender keeps offering items.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic flag(string what, logic [31:0] want, logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result checker. Signals are sampled right after the edge, so they hold
    // the values that took part in the handshake at that edge.
    // ------------------------------------------------------------------
    initial begin
        cvgf_out_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                if (pending_spans.size() == 0) begin
                    $display("%0t ns: result item with none expected, actual %h",
                             $time, m_item);
                    mismatches++;
                end else begin
                    want = pending_spans.pop_front();
                    if (m_item.status !== want.status)
                        flag("status", want.status, m_item.status);
                    if (m_item.row_address !== want.row_address)
                        flag("row_address", want.row_address, m_item.row_address);
                    if (m_item.span_words !== want.span_words)
                        flag("span_words", want.span_words, m_item.span_words);
                    if (m_item.pixel_value !== want.pixel_value)
                        flag("pixel_value", want.pixel_value, m_item.pixel_value);
                    if (m_item.last_row !== want.last_row)
                        flag("last_row", want.last_row, m_item.last_row);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int        sw, sh, x, y, w, h, kind, nexts, phase, random_start;
        cvgf_out_t invalid_res, idle_res, empty_res;

        invalid_res = mk_result(STAT_INVALID, '0, '0, '0, 1'b0);
        idle_res    = mk_result(STAT_IDLE, '0, '0, '0, 1'b0);
        empty_res   = mk_result(STAT_EMPTY, '0, '0, '0, 1'b0);

        // Directed table. Only results that are plain to see are typed in;
        // the rest go through the predictor.
        // Straight after reset the surface is not usable and nothing is
        // active, so a start is invalid and a next is idle.
        directed_plan.push_back(typed_row(mk_item(OP_START, 0, 0, 1, 1, '1, '1), invalid_res));
        directed_plan.push_back(typed_row(next_item(), idle_res));
        directed_plan.push_back(reg_row(CFG_BASE, 32'h1000_0000));
        directed_plan.push_back(reg_row(CFG_WIDTH, 32'd100));
        directed_plan.push_back(reg_row(CFG_HEIGHT, 32'd50));
        directed_plan.push_back(reg_row(CFG_STRIDE, 32'd400));
        directed_plan.push_back(reg_row(CFG_VALID, 32'd1));
        // Empty rectangles: zero width, most negative height, a negative
        // origin that eats the whole width, and an origin past the bottom.
        directed_plan.push_back(typed_row(mk_item(OP_START, 0, 0, 0, 5, '0, '0), empty_res));
        directed_plan.push_back(typed_row(mk_item(OP_START, 3, 3, 5, -32768, '0, '0),
                                          empty_res));
        directed_plan.push_back(typed_row(mk_item(OP_START, -32768, 0, 32767, 4, '0, '0),
                                          empty_res));
        directed_plan.push_back(typed_row(mk_item(OP_START, 10, 50, 5, 5, '0, '0), empty_res));
        // A one-pixel fill takes the top colour and is its own last row.
        directed_plan.push_back(typed_row(
            mk_item(OP_START, 0, 0, 1, 1, 32'hFFAA_BBCC, 32'h0011_2233),
            mk_result(STAT_ROW, 32'h1000_0000, 13'd1, 32'hFFAA_BBCC, 1'b1)));
        directed_plan.push_back(typed_row(next_item(), idle_res));
        // Maximal rectangle with negative origin, clipped on all four sides.
        directed_plan.push_back(item_row(
            mk_item(OP_START, -10, -5, 32767, 32767, 32'h0000_0000, 32'hFFFF_FFFF)));
        directed_plan.push_back(item_row(next_item()));
        directed_plan.push_back(item_row(next_item()));
        // A new start abandons that fill; red falls, blue rises here.
        directed_plan.push_back(item_row(
            mk_item(OP_START, 90, 45, 20, 20, 32'h00FF_0080, 32'h0000_00FF)));
        directed_plan.push_back(item_row(next_item()));
        // Registers changed in the middle of a fill: the new stride applies
        // to later rows, and dropping the valid flag does not stop the fill.
        directed_plan.push_back(reg_row(CFG_STRIDE, 32'd1000));
        directed_plan.push_back(reg_row(CFG_VALID, 32'd0));
        directed_plan.push_back(item_row(next_item()));
        directed_plan.push_back(item_row(next_item()));
        directed_plan.push_back(item_row(next_item()));
        directed_plan.push_back(item_row(next_item()));
        // Oversized surface, widest stride and a base that wraps the address.
        directed_plan.push_back(reg_row(CFG_VALID, 32'd1));
        directed_plan.push_back(reg_row(CFG_BASE, 32'hFFFF_FFF0));
        directed_plan.push_back(reg_row(CFG_WIDTH, 32'd8191));
        directed_plan.push_back(reg_row(CFG_HEIGHT, 32'd8191));
        directed_plan.push_back(reg_row(CFG_STRIDE, 32'd65535));
        directed_plan.push_back(typed_row(mk_item(OP_START, 32767, 0, 32767, 1, '0, '0),
                                          empty_res));
        directed_plan.push_back(item_row(
            mk_item(OP_START, 4095, 4095, 32767, 32767, 32'hFFFF_FFFF, 32'h0000_0000)));
        directed_plan.push_back(item_row(
            mk_item(OP_START, 0, 4094, 4096, 2, 32'h0000_0000, 32'h00FF_FFFF)));
        directed_plan.push_back(item_row(next_item()));
        // A zero-width surface leaves nothing to draw.
        directed_plan.push_back(reg_row(CFG_WIDTH, 32'd0));
        directed_plan.push_back(typed_row(mk_item(OP_START, 0, 0, 1, 1, '0, '0), empty_res));
        directed_plan.push_back(reg_row(CFG_BASE, 32'd0));
        directed_plan.push_back(reg_row(CFG_WIDTH, 32'd4096));
        directed_plan.push_back(reg_row(CFG_HEIGHT, 32'd4096));
        directed_plan.push_back(reg_row(CFG_STRIDE, 32'd0));
        directed_plan.push_back(item_row(
            mk_item(OP_START, -1, -1, 32767, 32767, 32'h1234_5678, 32'h89AB_CDEF)));
        directed_plan.push_back(item_row(next_item()));
        directed_plan.push_back(typed_row(mk_item(OP_START, 0, 0, -1, 3, '0, '0), empty_res));

        // Synchronous reset, held low from the start and then released once.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_reg) begin
                if (i == 0 || !directed_plan[i-1].is_reg)
                    settle();
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
                if (i == directed_plan.size() - 1 || !directed_plan[i+1].is_reg)
                    cfg_wr_en <= 1'b0;
            end else begin
                offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
            end
        end

        // Random phases. Each one starts from a fresh surface setting; a
        // phase may end inside a fill, so the next phase also exercises
        // register changes during a fill.
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_BASE, 32'h0000_0000);
                1:       write_reg(CFG_BASE, 32'hFFFF_FFFF);
                default: write_reg(CFG_BASE, $urandom);
            endcase
            write_reg(CFG_WIDTH, 32'(pick_dim()));
            write_reg(CFG_HEIGHT, 32'(pick_dim()));
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_STRIDE, 32'd0);
                1:       write_reg(CFG_STRIDE, 32'd65535);
                default: write_reg(CFG_STRIDE, 32'($urandom_range(0, 65535)));
            endcase
            write_reg(CFG_VALID, 32'($urandom_range(0, 99) < 85));
            cfg_wr_en <= 1'b0;

            // The first phase opens with a long receiver hold-off and the
            // second runs with no idle cycles on either side; one phase can
            // never reach the item count alone, so both always take place.
            idle_pct = (phase == 1) ? 0 : IDLE_PCT;
            if (phase == 0)
                hold_req = 1'b1;

            sw = (int'(width_r) > CVGF_MAX_DIM) ? CVGF_MAX_DIM : int'(width_r);
            sh = (int'(height_r) > CVGF_MAX_DIM) ? CVGF_MAX_DIM : int'(height_r);
            repeat ($urandom_range(30, 60)) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    // Well-formed fill: a start inside or just across the
                    // top-left edges, then a run of next items.
                    x = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 8))
                        : int'($urandom_range(0, (sw > 0) ? sw - 1 : 0));
                    y = ($urandom_range(0, 4) == 0) ? -int'($urandom_range(1, 8))
                        : int'($urandom_range(0, (sh > 0) ? sh - 1 : 0));
                    w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 32767))
                        : int'($urandom_range(1, 24));
                    h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 32767))
                        : int'($urandom_range(1, 10));
                    offer(mk_item(OP_START, x, y, w, h, pick_color(), pick_color()));
                    nexts = $urandom_range(0, ((h < 12) ? h : 12) + 1);
                    repeat (nexts) offer(next_item());
                end else if (kind < 85) begin
                    // Noise: every field drawn over its whole range.
                    offer(mk_item(logic'($urandom_range(0, 1)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom));
                end else begin
                    // Broken sequences: stray next items, non-positive sizes
                    // and rectangles that start beyond the right edge.
                    case ($urandom_range(0, 2))
                        0: offer(next_item());
                        1: offer(mk_item(OP_START, $urandom_range(0, 16), 0,
                                         -int'($urandom_range(0, 32768)),
                                         $urandom_range(1, 8), $urandom, $urandom));
                        default: offer(mk_item(OP_START, sw + int'($urandom_range(0, 64)),
                                               0, $urandom_range(1, 8),
                                               $urandom_range(1, 8), $urandom, $urandom));
                    endcase
                end
            end
            phase++;
        end

        // Drain: wait for every expected result, then give the block time to
        // show any result that should not be there.
        s_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_spans.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
